// ===== rtl/core/pbfe_pkg.sv =====
// Shared types and constants for the protobuf field encoder.
package pbfe_pkg;

    // Command codes carried in the input tuser.
    localparam logic [1:0] CMD_FIELD  = 2'd0;
    localparam logic [1:0] CMD_HEADER = 2'd1;
    localparam logic [1:0] CMD_RAW    = 2'd2;
    localparam logic [1:0] CMD_BARE   = 2'd3;

    localparam int FIELD_W = 29;
    localparam int VALUE_W = 64;
    localparam int TAG_W   = FIELD_W + 3;
    localparam int BYTE_W  = 8;
    localparam int GROUP_W = 7;

    // Wire types placed in the low bits of a tag.
    localparam logic [2:0] WIRE_VARINT = 3'd0;
    localparam logic [2:0] WIRE_LEN    = 3'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // What the back end has to do with a queued entry.
    typedef enum logic [1:0] {
        OP_TAGGED,
        OP_BARE,
        OP_RAW
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TAG,
        ST_VAL,
        ST_RAW
    } bst_t;

    typedef struct packed {
        op_t                op;
        logic [TAG_W-1:0]   tag;
        logic [VALUE_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

// ===== rtl/core/protobuf_field_encoder_core.sv =====
// Top level of the protobuf wire-format field encoder.
//
// Input words arrive on the s_ channel. s_tuser selects the command: varint
// field, length-delimited header, payload byte or bare varint. The front end
// builds the tag (field number shifted left by three, with the wire type) and
// places the command in a two-entry queue; a header of length zero is taken
// and dropped without output. The back end takes one entry at a time and
// sends the tag varint (not for a bare one) and then the value varint, seven
// bits per byte with the continuation bit on all but the final byte, or the raw payload byte.
// m_tlast marks the final byte of each command.
//
// On an empty block the first byte of a command passes through the queue, the
// back end's pick-up of the entry from idle and the output register. The back
// end has a single byte register and takes a new entry only when idle, so the
// last byte of a command is registered before the next command is picked up.
// The queue keeps accepting words while the back end works.
//
// Reset empties the queue and the output register. When the receiver holds
// m_tready low the byte stays in the output register, the back end waits,
// and once the queue fills s_tready falls.
module protobuf_field_encoder_core
    import pbfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [103:0] s_tdata,   // field_number[28:0], value[92:29], data_byte[100:93], zero pad
    input  logic [1:0]   s_tuser,   // cmd[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,   // out_byte[7:0]
    output logic         m_tlast
);

    qstat_t qstat;
    logic   push;
    logic   pop;
    entry_t push_entry;
    entry_t pop_entry;

    // Classification of incoming words.
    pbfe_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .qstat      (qstat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decoupling queue, so each side may stall without the other.
    pbfe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .qstat      (qstat)
    );

    // Byte serializer with its output register.
    pbfe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/core/pbfe_front.sv =====
// Front end: accepts commands, builds the tag and drops empty headers.
module pbfe_front
    import pbfe_pkg::*;
(
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [103:0]       s_tdata,
    input  logic [1:0]         s_tuser,
    input  qstat_t             qstat,
    output logic               push,
    output entry_t             push_entry
);

    logic [FIELD_W-1:0] field_number;
    logic [VALUE_W-1:0] value;
    logic [BYTE_W-1:0]  data_byte;
    logic [1:0]         cmd;
    logic               skip;

    assign field_number = s_tdata[FIELD_W-1:0];
    assign value        = s_tdata[FIELD_W+VALUE_W-1:FIELD_W];
    assign data_byte    = s_tdata[FIELD_W+VALUE_W+BYTE_W-1:FIELD_W+VALUE_W];
    assign cmd          = s_tuser;

    assign s_tready = !qstat.full;

    // A header whose length is zero is consumed without producing any byte.
    assign skip = (cmd == CMD_HEADER) && (value == '0);
    assign push = s_tvalid && s_tready && !skip;

    always_comb
    begin
        push_entry.tag   = {field_number, WIRE_VARINT};
        push_entry.value = value;
        push_entry.op    = OP_TAGGED;
        unique case (cmd)
            CMD_FIELD:
            begin
                push_entry.op = OP_TAGGED;
            end
            CMD_HEADER:
            begin
                push_entry.op  = OP_TAGGED;
                push_entry.tag = {field_number, WIRE_LEN};
            end
            CMD_RAW:
            begin
                push_entry.op    = OP_RAW;
                push_entry.value = {{(VALUE_W-BYTE_W){1'b0}}, data_byte};
            end
            default:
            begin
                push_entry.op = OP_BARE;
            end
        endcase
    end

endmodule

// ===== rtl/core/pbfe_queue.sv =====
// Short queue of classified commands between the front and back ends.
module pbfe_queue
    import pbfe_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t pop_entry,
    output qstat_t qstat
);

    entry_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;

    assign qstat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign qstat.empty = (count_reg == '0);
    assign pop_entry   = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                              : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && qstat.full))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && qstat.empty))
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

// ===== rtl/core/pbfe_back.sv =====
// Back end: turns queued entries into varint or raw payload bytes through an output register.
module pbfe_back
    import pbfe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qstat_t       qstat,
    input  entry_t       pop_entry,
    output logic         pop,
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);

    bst_t               state_reg, state_next;
    logic [TAG_W-1:0]   tag_reg, tag_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic               out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]  out_byte_reg, out_byte_next;
    logic               out_last_reg, out_last_next;
    logic               slot_free;
    logic               tag_more;
    logic               val_more;

    assign slot_free = !out_valid_reg || m_tready;
    assign tag_more  = |tag_reg[TAG_W-1:GROUP_W];
    assign val_more  = |val_reg[VALUE_W-1:GROUP_W];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next     = state_reg;
        tag_next       = tag_reg;
        val_next       = val_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop      = 1'b1;
                    tag_next = pop_entry.tag;
                    val_next = pop_entry.value;
                    unique case (pop_entry.op)
                        OP_TAGGED: state_next = ST_TAG;
                        OP_RAW:    state_next = ST_RAW;
                        default:   state_next = ST_VAL;
                    endcase
                end
            end
            ST_TAG:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {tag_more, tag_reg[GROUP_W-1:0]};
                    out_last_next  = 1'b0;
                    tag_next       = tag_reg >> GROUP_W;
                    if (!tag_more)
                    begin
                        state_next = ST_VAL;
                    end
                end
            end
            ST_VAL:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {val_more, val_reg[GROUP_W-1:0]};
                    out_last_next  = !val_more;
                    val_next       = val_reg >> GROUP_W;
                    if (!val_more)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RAW:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = val_reg[BYTE_W-1:0];
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg      <= tag_next;
        val_reg      <= val_next;
        out_byte_reg <= out_byte_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTH
    a_pop_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> state_reg != ST_IDLE)
        else $error("entry taken but back end stayed idle");
    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == ST_IDLE)
        else $error("entry taken while busy");
    a_tag_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TAG && slot_free) |=> !out_last_reg)
        else $error("tag byte marked as last");
`endif

endmodule

// ===== tb/tb_protobuf_field_encoder_core.sv =====
`timescale 1ns / 1ps
// Self-checking stream testbench for the protobuf field encoder core.
module tb_protobuf_field_encoder_core;
    import pbfe_pkg::*;

    localparam int RESET_CYCLES   = 9;
    localparam int STALL_PCT      = 22;
    localparam int RANDOM_ITEMS   = 127;
    localparam int QUIET_ITEMS    = 50;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;

    // One byte of the encoded wire stream as it should leave the block.
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
    } wire_byte_t;

    // One command word. Where known is set, n_exp and bytes hold the wire
    // bytes typed in by hand, first byte in the lowest bits.
    typedef struct packed {
        logic [1:0]         cmd;
        logic [FIELD_W-1:0] fnum;
        logic [VALUE_W-1:0] val;
        logic [BYTE_W-1:0]  dbyte;
        logic               known;
        logic [4:0]         n_exp;
        logic [119:0]       bytes;
    } cmd_word_t;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] s_tdata;    // field_number[28:0], value[92:29], data_byte[100:93], zero pad
    logic [1:0]   s_tuser;    // cmd[1:0]
    logic         m_tvalid;
    logic         m_tready;
    logic [7:0]   m_tdata;    // out_byte[7:0]
    logic         m_tlast;

    wire_byte_t wire_q[$];    // wire bytes still owed by the block, oldest first
    wire_byte_t want;
    bit         stall_en;
    int         err_count = 0;
    int         bytes_checked = 0;
    int         quiet_cycles = 0;
    int         cmd_seen[4];

    protobuf_field_encoder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Appends the base-128 varint of v; the byte count follows from the
    // highest set bit, and zero still takes one byte.
    function automatic void push_varint(input logic [63:0] v, input bit ends_item);
        int msb;
        int nbytes;
        logic [7:0] b;
        msb = 0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
                msb = i + 1;
        end
        nbytes = (msb + 6) / 7;
        if (nbytes == 0)
            nbytes = 1;
        for (int k = 0; k < nbytes; k++)
        begin
            b = {1'b0, 7'(v >> (7 * k))};
            if (k != nbytes - 1)
                b[7] = 1'b1;
            wire_q.push_back('{b, ends_item && (k == nbytes - 1)});
        end
    endfunction

    // Works out the wire bytes of one command word.
    function automatic void encode_item(input cmd_word_t w);
        case (w.cmd)
            CMD_FIELD:
            begin
                push_varint({32'd0, w.fnum, WIRE_VARINT}, 1'b0);
                push_varint(w.val, 1'b1);
            end
            CMD_HEADER:
            begin
                // A header of zero length puts nothing on the wire.
                if (w.val != 64'd0)
                begin
                    push_varint({32'd0, w.fnum, WIRE_LEN}, 1'b0);
                    push_varint(w.val, 1'b1);
                end
            end
            CMD_RAW:
                wire_q.push_back('{w.dbyte, 1'b1});
            default:
                push_varint(w.val, 1'b1);
        endcase
    endfunction

    // Presents one word, waits for the handshake and books its wire bytes.
    task automatic send_word(input cmd_word_t w);
        while (stall_en && ($urandom_range(0, 99) < STALL_PCT))
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'd0, w.dbyte, w.val, w.fnum};
        s_tuser  <= w.cmd;
        do
            @(posedge clk);
        while (!s_tready);
        if (w.known)
        begin
            for (int k = 0; k < w.n_exp; k++)
                wire_q.push_back('{w.bytes[8 * k +: 8], k == w.n_exp - 1});
        end
        else
        begin
            encode_item(w);
        end
        cmd_seen[w.cmd]++;
        @(negedge clk);
    endtask

    // Receiver: back-pressure changes at the falling edge.
    always @(negedge clk)
        m_tready <= !(stall_en && ($urandom_range(0, 99) < STALL_PCT));

    // Output checker: every accepted byte is matched against the oldest one owed.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (wire_q.size() == 0)
            begin
                $error("unexpected word: out_byte %h, last %b", m_tdata, m_tlast);
                err_count++;
            end
            else
            begin
                want = wire_q.pop_front();
                bytes_checked++;
                if (m_tdata !== want.out_byte)
                begin
                    $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
                    err_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake on either side ends the run.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $error("no word moved for %0d cycles, %0d bytes still owed",
                       quiet_cycles, wire_q.size());
                $display("tb_protobuf_field_encoder_core: errors");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    initial
    begin
        cmd_word_t dir_rows[$];
        cmd_word_t w;
        int        n_dir;
        int        n_rand;
        int        len;
        int        pick;
        logic [63:0] raw;

        rst_n        <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tdata      <= '0;
        s_tuser      <= CMD_FIELD;
        m_tready     <= 1'b0;
        stall_en     = 1'b1;
        n_dir        = 0;
        n_rand       = 0;

        // Directed words. Typed-in bytes read from the right: the lowest
        // byte leaves the block first.
        dir_rows.push_back('{CMD_BARE, 29'd0, 64'd0, 8'd0, 1'b1, 5'd1, 120'h00});
        dir_rows.push_back('{CMD_BARE, 29'd0, 64'd1, 8'd0, 1'b1, 5'd1, 120'h01});
        dir_rows.push_back('{CMD_BARE, 29'd0, 64'd127, 8'd0, 1'b1, 5'd1, 120'h7F});
        dir_rows.push_back('{CMD_BARE, 29'd0, 64'd128, 8'd0, 1'b1, 5'd2, 120'h01_80});
        dir_rows.push_back('{CMD_BARE, '1, '1, '1, 1'b1, 5'd10,
                             120'h01_FF_FF_FF_FF_FF_FF_FF_FF_FF});
        // Payload bytes ignore the field number and the value.
        dir_rows.push_back('{CMD_RAW, '1, '1, 8'hA5, 1'b1, 5'd1, 120'hA5});
        dir_rows.push_back('{CMD_RAW, 29'd0, 64'd0, 8'h00, 1'b1, 5'd1, 120'h00});
        dir_rows.push_back('{CMD_RAW, 29'd0, 64'd0, 8'hFF, 1'b1, 5'd1, 120'hFF});
        // A header of zero length is taken and produces nothing.
        dir_rows.push_back('{CMD_HEADER, '1, 64'd0, '1, 1'b1, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_HEADER, 29'd2, 64'd3, 8'd0, 1'b1, 5'd2, 120'h03_12});
        dir_rows.push_back('{CMD_FIELD, 29'd1, 64'd150, '1, 1'b1, 5'd3, 120'h01_96_08});
        dir_rows.push_back('{CMD_FIELD, 29'd0, 64'd0, 8'd0, 1'b1, 5'd2, 120'h00_00});
        // Widest case: five tag bytes and ten value bytes.
        dir_rows.push_back('{CMD_FIELD, '1, '1, 8'd0, 1'b1, 5'd15,
                             120'h01_FF_FF_FF_FF_FF_FF_FF_FF_FF_0F_FF_FF_FF_F8});
        dir_rows.push_back('{CMD_HEADER, '1, '1, 8'd0, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_HEADER, 29'd15, 64'd1, 8'd0, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_HEADER, 29'd16, 64'd1, 8'd0, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_HEADER, 29'd0, 64'd1, '1, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_FIELD, 29'd16, 64'h3FFF, 8'd0, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_FIELD, 29'h10000, 64'h4000, 8'd0, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_BARE, '1, 64'h8000_0000_0000_0000, '1, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_BARE, 29'd0, 64'h7FFF_FFFF_FFFF_FFFF, 8'd0, 1'b0, 5'd0,
                             120'h0});
        dir_rows.push_back('{CMD_BARE, 29'd0, 64'd16383, 8'd0, 1'b0, 5'd0, 120'h0});
        dir_rows.push_back('{CMD_BARE, 29'd0, 64'd16384, 8'd0, 1'b0, 5'd0, 120'h0});

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            send_word(dir_rows[i]);
            n_dir++;
        end

        // Random commands. The first stretch runs with no idling on either side.
        stall_en = 1'b0;
        while (n_rand < RANDOM_ITEMS)
        begin
            if (n_rand == QUIET_ITEMS)
                stall_en = 1'b1;
            w.cmd   = 2'($urandom_range(0, 3));
            w.dbyte = 8'($urandom);
            // Half of the field numbers are small so the tag length varies.
            pick = $urandom_range(0, 3);
            if (pick == 0)
                w.fnum = FIELD_W'($urandom_range(1, 15));
            else if (pick == 1)
                w.fnum = FIELD_W'($urandom_range(16, 2047));
            else
                w.fnum = FIELD_W'($urandom);
            // Value length is spread evenly, with the top bit of that length set.
            len = $urandom_range(0, 64);
            raw = {$urandom, $urandom};
            if (len == 64)
                w.val = raw;
            else
                w.val = raw & ((64'd1 << len) - 64'd1);
            if (len > 0)
                w.val[len - 1] = 1'b1;
            if ((w.cmd == CMD_HEADER) && ($urandom_range(0, 9) == 0))
                w.val = 64'd0;
            w.known = 1'b0;
            w.n_exp = 5'd0;
            w.bytes = '0;
            send_word(w);
            n_rand++;
        end
        s_tvalid <= 1'b0;

        // Drain: the watchdog catches bytes that never come.
        while (wire_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d directed and %0d random commands: %0d fields, %0d headers,",
                 n_dir, n_rand, cmd_seen[CMD_FIELD], cmd_seen[CMD_HEADER]);
        $display("%0d payload bytes, %0d bare varints; %0d wire bytes compared.",
                 cmd_seen[CMD_RAW], cmd_seen[CMD_BARE], bytes_checked);
        if (err_count == 0)
            $display("tb_protobuf_field_encoder_core: clean");
        else
            $display("tb_protobuf_field_encoder_core: errors");
        $finish;
    end

endmodule
